### rtl/polyphonic_sample_mixer_assert.svh
// Assertion macros shared by the checker.
`ifndef POLYPHONIC_SAMPLE_MIXER_ASSERT_SVH
`define POLYPHONIC_SAMPLE_MIXER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PSM_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PSM_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### rtl/psm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package psm_pkg;
  localparam int TRACKS_DEF = 8;
  localparam int INSTRUMENTS_DEF = 8;
  localparam int SAMPLE_WORDS_DEF = 65536;
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TRIGGER = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;
  localparam logic [2:0] INST_OPEN_HAT = 3'd6;
  localparam logic [2:0] INST_CLOSED_HAT = 3'd7;
  localparam logic [12:0] MASTER_GAIN_RESET = 13'd4096;
  localparam int GAIN_SHIFT = 12;
endpackage
`default_nettype wire

### rtl/polyphonic_sample_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// Drum voice mixer. Load, trigger and ignored transactions are taken in the idle
// state and leave it idle. A tick leaves the idle state, so the input stays closed until
// the tick is done. The sequencer then visits every track once, presenting the
// sample read in a read state and accumulating the returned data in an
// accumulate state. After that it scales the mix by the master gain in a scale
// state and saturates the result in a done state. The sample RAM's read data is
// used only during the track walk, and the RAM is written only by loads while the
// sequencer is idle. The result goes into an output register, and the next
// transaction is taken while it waits. A following tick finishes its walk and then
// holds in its done state until that register has been read. Track state lives in
// flip-flops; samples live in the RAM.
module polyphonic_sample_mixer #(
  parameter int TRACKS = psm_pkg::TRACKS_DEF,
  parameter int INSTRUMENTS = psm_pkg::INSTRUMENTS_DEF,
  parameter int SAMPLE_WORDS = psm_pkg::SAMPLE_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_address,
  input  wire logic signed [15:0] in_sample_value,
  input  wire logic [2:0]  in_instrument,
  input  wire logic [14:0] in_length,
  input  wire logic [12:0] in_voice_gain,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_mixed_sample,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_master_gain
);
  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam int IW = $clog2(INSTRUMENTS);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_ACC, S_SCALE, S_DONE} state_t;
  state_t state_r;

  logic [12:0] master_r;
  logic [TW-1:0] ring_r [TRACKS];
  logic [TW-1:0] head_r, tail_r, k_r;
  logic busy_r [TRACKS];
  logic [IW-1:0] inst_r [TRACKS];
  logic [15:0] ptr_r [TRACKS];
  logic [14:0] rem_r [TRACKS];
  logic [12:0] gain_r [TRACKS];
  logic oh_valid_r;
  logic [TW-1:0] oh_track_r;
  logic signed [31:0] sum_r;
  logic signed [47:0] prod_r;
  logic [15:0] out_r;
  logic out_valid_r;
  logic take_r;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic signed [15:0] ram_rdata;
  logic signed [29:0] vprod;
  logic signed [47:0] mixv;
  logic out_load;

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_mixed_sample = out_r;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign ram_we = in_valid && in_ready && (in_kind == psm_pkg::KIND_LOAD);
  assign ram_addr = in_address[AW-1:0];

  psm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_addr), .wdata(in_sample_value),
    .raddr(ptr_r[k_r][AW-1:0]), .rdata(ram_rdata)
  );

  assign vprod = ram_rdata * $signed({1'b0, gain_r[k_r]});
  assign mixv = prod_r >>> psm_pkg::GAIN_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      master_r <= psm_pkg::MASTER_GAIN_RESET;
      head_r <= '0;
      tail_r <= '0;
      k_r <= '0;
      oh_valid_r <= 1'b0;
      oh_track_r <= '0;
      out_valid_r <= 1'b0;
      take_r <= 1'b0;
      for (int i = 0; i < TRACKS; i++) begin
        ring_r[i] <= TW'(i);
        busy_r[i] <= 1'b0;
        inst_r[i] <= '0;
        ptr_r[i] <= '0;
        rem_r[i] <= '0;
        gain_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        master_r <= cfg_master_gain;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_kind == psm_pkg::KIND_TRIGGER) begin
              // The track being started gets its new length below.
              if (in_instrument == psm_pkg::INST_OPEN_HAT ||
                  in_instrument == psm_pkg::INST_CLOSED_HAT) begin
                for (int i = 0; i < TRACKS; i++) begin
                  if (busy_r[i] && inst_r[i] == IW'(psm_pkg::INST_OPEN_HAT) &&
                      !(oh_valid_r && oh_track_r == TW'(i)) &&
                      TW'(i) != ring_r[head_r]) begin
                    rem_r[i] <= '0;
                  end
                end
              end
              busy_r[ring_r[head_r]] <= 1'b1;
              inst_r[ring_r[head_r]] <= IW'(in_instrument);
              ptr_r[ring_r[head_r]] <= in_address;
              rem_r[ring_r[head_r]] <= in_length;
              gain_r[ring_r[head_r]] <= in_voice_gain;
              head_r <= (head_r == TW'(TRACKS - 1)) ? '0 : head_r + 1'b1;
              if (in_instrument == psm_pkg::INST_OPEN_HAT) begin
                oh_valid_r <= 1'b1;
                oh_track_r <= ring_r[head_r];
              end
            end else if (in_kind == psm_pkg::KIND_TICK) begin
              sum_r <= '0;
              k_r <= '0;
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          // Sample address was presented this cycle; data arrives next.
          take_r <= busy_r[k_r] && rem_r[k_r] != '0;
          if (busy_r[k_r] && rem_r[k_r] == '0) begin
            ring_r[tail_r] <= k_r;
            tail_r <= (tail_r == TW'(TRACKS - 1)) ? '0 : tail_r + 1'b1;
            busy_r[k_r] <= 1'b0;
          end
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (take_r) begin
            sum_r <= sum_r + 32'(vprod >>> psm_pkg::GAIN_SHIFT);
            ptr_r[k_r] <= ptr_r[k_r] + 16'd1;
            rem_r[k_r] <= rem_r[k_r] - 15'd1;
          end
          if (k_r == TW'(TRACKS - 1)) begin
            state_r <= S_SCALE;
          end else begin
            k_r <= k_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_SCALE: begin
          prod_r <= sum_r * $signed({1'b0, master_r});
          oh_valid_r <= 1'b0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          // Holds here while the previous result is still unread.
          if (out_load) begin
            if (mixv > 48'sd32767) begin
              out_r <= 16'hFFFF;
            end else if (mixv < -48'sd32768) begin
              out_r <= 16'h0000;
            end else begin
              out_r <= mixv[15:0] ^ 16'h8000;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/psm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module psm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/psm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "polyphonic_sample_mixer_assert.svh"
module psm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_kind,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [15:0] out_mixed_sample
);
  logic in_fire;
  logic in_tick;

  assign in_fire = in_valid && in_ready;
  assign in_tick = in_fire && in_kind == psm_pkg::KIND_TICK;

  // A tick keeps the input closed while the tracks are walked.
  `PSM_ASSERT_NEXT(a_tick_busy, clk, rst_n, in_tick, !in_ready)
  // Loads, triggers and ignored transactions accepted while no result waits never produce one on the next edge.
  `PSM_ASSERT_NEXT(a_no_spurious, clk, rst_n, in_fire && !in_tick && !out_valid, !out_valid)
  // A waiting result holds its value.
  `PSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_mixed_sample))
endmodule
bind polyphonic_sample_mixer psm_checker u_psm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_kind(in_kind), .out_valid(out_valid), .out_ready(out_ready),
  .out_mixed_sample(out_mixed_sample)
);
`default_nettype wire

### test/polyphonic_sample_mixer_tb.sv
`timescale 1ns / 1ps
module polyphonic_sample_mixer_tb;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;

  class mix_scoreboard;
    shortint     mem [65536];
    bit          written [65536];
    bit [2:0]    ring [8];
    bit [2:0]    head;
    bit [2:0]    tail;
    bit          busy [8];
    bit [2:0]    inst [8];
    bit [15:0]   ptr [8];
    bit [14:0]   remain [8];
    bit [12:0]   gain [8];
    bit          hat_valid;
    bit [2:0]    hat_track;
    bit [12:0]   master;
    bit [15:0]   pending [$];
    int          errors;
    int          checked;
    int          steals;
    int          clamps;

    function new();
      for (int i = 0; i < 8; i++) begin
        ring[i] = i[2:0];
        busy[i] = 0;
        inst[i] = 0;
        ptr[i] = 0;
        remain[i] = 0;
        gain[i] = 0;
      end
      head = 0;
      tail = 0;
      hat_valid = 0;
      hat_track = 0;
      master = psm_pkg::MASTER_GAIN_RESET;
      errors = 0;
      checked = 0;
      steals = 0;
      clamps = 0;
    endfunction

    // Returns an address that the next tick would read without it ever being loaded.
    function int unread_address();
      for (int k = 0; k < 8; k++)
        if (busy[k] && remain[k] != 0 && !written[ptr[k]]) return ptr[k];
      return -1;
    endfunction

    function void note_input(bit [1:0] kind, bit [15:0] addr, bit [15:0] value,
                             bit [2:0] ins, bit [14:0] len, bit [12:0] vgain);
      bit [2:0] t;
      longint   sum;
      longint   mix;
      sum = 0;
      if (kind == psm_pkg::KIND_LOAD) begin
        mem[addr] = shortint'(value);
        written[addr] = 1;
      end else if (kind == psm_pkg::KIND_TRIGGER) begin
        if (ins == psm_pkg::INST_OPEN_HAT || ins == psm_pkg::INST_CLOSED_HAT)
          for (int k = 0; k < 8; k++)
            if (busy[k] && inst[k] == psm_pkg::INST_OPEN_HAT &&
                !(hat_valid && hat_track == k))
              remain[k] = 0;
        t = ring[head];
        head = head + 1;
        if (busy[t]) steals++;
        busy[t] = 1;
        inst[t] = ins;
        ptr[t] = addr;
        remain[t] = len;
        gain[t] = vgain;
        if (ins == psm_pkg::INST_OPEN_HAT) begin
          hat_valid = 1;
          hat_track = t;
        end
      end else if (kind == psm_pkg::KIND_TICK) begin
        for (int k = 0; k < 8; k++) begin
          if (busy[k]) begin
            if (remain[k] == 0) begin
              ring[tail] = k[2:0];
              tail = tail + 1;
              busy[k] = 0;
            end else begin
              // Arithmetic shift of the signed product is the floor division by 4096.
              sum += (longint'(mem[ptr[k]]) * longint'(gain[k])) >>> psm_pkg::GAIN_SHIFT;
              ptr[k] = ptr[k] + 1;
              remain[k] = remain[k] - 1;
            end
          end
        end
        hat_valid = 0;
        mix = (sum * longint'(master)) >>> psm_pkg::GAIN_SHIFT;
        if (mix > 32767 || mix < -32768) clamps++;
        if (mix > 32767) mix = 32767;
        if (mix < -32768) mix = -32768;
        pending.push_back(16'(mix + 32768));
      end
    endfunction

    function void check_result(bit [15:0] got);
      bit [15:0] want;
      if (pending.size() == 0) begin
        $display("%0t: mixed_sample with nothing expected: expected none, actual %0d",
                 $time, got);
        errors++;
      end else begin
        want = pending.pop_front();
        checked++;
        if (got !== want) begin
          $display("%0t: mixed_sample mismatch: expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [15:0] in_address;
  logic [15:0] in_sample_value;
  logic [2:0]  in_instrument;
  logic [14:0] in_length;
  logic [12:0] in_voice_gain;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_mixed_sample;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_master_gain;

  mix_scoreboard sb;
  bit  no_gaps;
  int  cycles;
  int  ticks_sent;
  int  items_sent;

  polyphonic_sample_mixer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_address(in_address), .in_sample_value(in_sample_value),
    .in_instrument(in_instrument), .in_length(in_length), .in_voice_gain(in_voice_gain),
    .out_valid(out_valid), .out_ready(out_ready), .out_mixed_sample(out_mixed_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_master_gain(cfg_master_gain)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("polyphonic_sample_mixer verification failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_mixed_sample);

  // Result side: random stall before each result, none while no_gaps is set.
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = no_gaps ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15));
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send(bit [1:0] kind, bit [15:0] addr, bit [15:0] value,
                      bit [2:0] ins, bit [14:0] len, bit [12:0] vgain);
    int gap;
    gap = no_gaps ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_address <= addr;
    in_sample_value <= value;
    in_instrument <= ins;
    in_length <= len;
    in_voice_gain <= vgain;
    do @(posedge clk); while (!in_ready);
    sb.note_input(kind, addr, value, ins, len, vgain);
    items_sent++;
  endtask

  task automatic load(bit [15:0] addr, bit [15:0] value);
    send(psm_pkg::KIND_LOAD, addr, value, 3'($urandom), 15'($urandom), 13'($urandom));
  endtask

  task automatic trigger(bit [15:0] addr, bit [2:0] ins, bit [14:0] len, bit [12:0] vgain);
    send(psm_pkg::KIND_TRIGGER, addr, 16'($urandom), ins, len, vgain);
  endtask

  // Every word a tick will read is loaded first, so no unwritten memory is read.
  task automatic tick();
    int a;
    a = sb.unread_address();
    while (a >= 0) begin
      load(a[15:0], 16'($urandom));
      a = sb.unread_address();
    end
    send(psm_pkg::KIND_TICK, 16'($urandom), 16'($urandom), 3'($urandom), 15'($urandom),
         13'($urandom));
    ticks_sent++;
  endtask

  task automatic settle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_master(bit [12:0] value);
    in_valid <= 1'b0;
    settle();
    cfg_valid <= 1'b1;
    cfg_master_gain <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.master = value;
  endtask

  // Runs until about count more transactions have been sent, loads ahead of ticks included.
  task automatic random_items(int count);
    int pick;
    int stop;
    bit [14:0] len;
    bit [12:0] vgain;
    bit [2:0]  ins;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        case ($urandom_range(0, 9))
          0: len = 15'h7FFF;
          1: len = 15'($urandom);
          2: len = 0;
          default: len = 15'($urandom_range(1, 40));
        endcase
        vgain = ($urandom_range(0, 4) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4096));
        if ($urandom_range(0, 2) == 0)
          ins = $urandom_range(0, 1) ? psm_pkg::INST_OPEN_HAT : psm_pkg::INST_CLOSED_HAT;
        else
          ins = 3'($urandom);
        trigger(16'($urandom), ins, len, vgain);
      end else if (pick < 78) begin
        tick();
      end else if (pick < 95) begin
        load(16'($urandom), 16'($urandom));
      end else begin
        send(KIND_IGNORED, 16'($urandom), 16'($urandom), 3'($urandom), 15'($urandom),
             13'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    ticks_sent = 0;
    items_sent = 0;
    no_gaps = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= psm_pkg::KIND_LOAD;
    in_address <= 16'd0;
    in_sample_value <= 16'd0;
    in_instrument <= 3'd0;
    in_length <= 15'd0;
    in_voice_gain <= 13'd0;
    cfg_valid <= 1'b0;
    cfg_master_gain <= psm_pkg::MASTER_GAIN_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme words, pointer wrap, hat cuts, zero length, stealing.
    tick();
    load(16'hFFFF, 16'h7FFF);
    load(16'h0000, 16'h8000);
    trigger(16'hFFFF, 3'd0, 15'd3, 13'h1FFF);
    trigger(16'hFFFF, 3'd1, 15'd2, 13'd4096);
    tick();
    tick();
    trigger(16'h0000, psm_pkg::INST_OPEN_HAT, 15'd20, 13'd4096);
    trigger(16'h0000, psm_pkg::INST_OPEN_HAT, 15'd20, 13'd2048);
    trigger(16'h0000, psm_pkg::INST_OPEN_HAT, 15'd20, 13'd1024);
    tick();
    trigger(16'hFFFF, psm_pkg::INST_CLOSED_HAT, 15'd0, 13'd0);
    tick();
    for (int i = 0; i < 9; i++)
      trigger(16'hFFFF, 3'(i), 15'h7FFF, 13'h1FFF);
    send(KIND_IGNORED, 16'hFFFF, 16'hFFFF, 3'd7, 15'h7FFF, 13'h1FFF);
    tick();
    tick();

    write_master(13'd0);
    random_items(90);
    write_master(13'h1FFF);
    no_gaps = 1;
    random_items(90);
    no_gaps = 0;
    write_master(13'd1);
    random_items(45);
    // Hold the sender until the result side has caught up.
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    random_items(45);
    write_master(13'($urandom_range(1, 4095)));
    random_items(90);
    write_master(psm_pkg::MASTER_GAIN_RESET);
    random_items(90);
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d ticks under six master gain settings, %0d results checked.",
             ticks_sent, sb.checked);
    $display("Tracks stolen from a full ring: %0d; mixes clamped: %0d.",
             sb.steals, sb.clamps);
    if (sb.errors == 0) begin
      $display("polyphonic_sample_mixer verification clean");
    end else begin
      $display("polyphonic_sample_mixer verification failed");
    end
    $finish;
  end
endmodule

### polyphonic_sample_mixer.f
+incdir+rtl
rtl/psm_pkg.sv
rtl/psm_ram.sv
rtl/polyphonic_sample_mixer.sv
rtl/psm_checker.sv
test/polyphonic_sample_mixer_tb.sv
